>>> src/fwsts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fwsts_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam int ID_W = 16;
   localparam int TIME_W = 16;
   localparam int QUERY_W = 20;
   localparam int OP_W = 2;
   localparam int STATUS_W = 2;

   // The running sum must hold every stored time plus one bit over the query range.
   localparam int SUM_W = (TIME_W + CNT_W > QUERY_W + 1) ? TIME_W + CNT_W : QUERY_W + 1;

   localparam int REQ_FIELDS_W = ID_W + TIME_W + QUERY_W;
   localparam int REQ_TDATA_W = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = ID_W + TIME_W + 1;
   localparam int RSP_TDATA_W = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef enum logic [OP_W-1:0] {
      OP_ENQUEUE = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_PEEK    = 2'd2,
      OP_FIND    = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   // Where the result payload comes from when the result is captured.
   typedef enum logic [1:0] {
      RES_CODE,
      RES_PEEK,
      RES_HIT
   } res_kind_type;

   typedef struct packed {
      logic         latch;
      logic         do_enq;
      logic         do_deq;
      logic         walk_start;
      logic         walk_step;
      logic         res_we;
      res_kind_type res_kind;
      status_type   res_status;
      logic         out_load;
   } dp_cmd_type;

   typedef struct packed {
      op_type op;
      logic   empty;
      logic   full;
      logic   hit;
      logic   last;
   } dp_stat_type;

   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] slot);
      logic [IDX_W-1:0] nxt;
      if (slot == IDX_W'(DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = slot + 1'b1;
      end
      return nxt;
   endfunction

endpackage

`default_nettype wire

>>> src/fwsts_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module fwsts_dp (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire fwsts_pkg::dp_cmd_type               cmd,
   output fwsts_pkg::dp_stat_type                   stat,
   input  wire logic [fwsts_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  wire logic [fwsts_pkg::OP_W-1:0]          req_tuser,
   output logic [fwsts_pkg::RSP_TDATA_W-1:0]        rsp_tdata,
   output logic [fwsts_pkg::STATUS_W-1:0]           rsp_tuser
);

   logic [fwsts_pkg::ID_W-1:0]   id_mem [fwsts_pkg::DEPTH];
   logic [fwsts_pkg::TIME_W-1:0] time_mem [fwsts_pkg::DEPTH];

   fwsts_pkg::op_type              op_ff;
   logic [fwsts_pkg::ID_W-1:0]     new_id_ff;
   logic [fwsts_pkg::TIME_W-1:0]   new_time_ff;
   logic [fwsts_pkg::QUERY_W-1:0]  query_ff;

   logic [fwsts_pkg::IDX_W-1:0]    head_ff, head_in;
   logic [fwsts_pkg::IDX_W-1:0]    tail_ff, tail_in;
   logic [fwsts_pkg::CNT_W-1:0]    count_ff, count_in;

   logic [fwsts_pkg::IDX_W-1:0]    walk_slot_ff, walk_slot_in;
   logic [fwsts_pkg::CNT_W-1:0]    seen_ff, seen_in;
   logic [fwsts_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic [fwsts_pkg::SUM_W-1:0]    sum_next;

   logic [fwsts_pkg::IDX_W-1:0]    rd_addr;
   logic [fwsts_pkg::ID_W-1:0]     rd_id_ff;
   logic [fwsts_pkg::TIME_W-1:0]   rd_time_ff;

   fwsts_pkg::status_type          res_status_ff;
   logic [fwsts_pkg::ID_W-1:0]     res_id_ff;
   logic [fwsts_pkg::TIME_W-1:0]   res_time_ff;

   fwsts_pkg::status_type          out_status_ff;
   logic [fwsts_pkg::ID_W-1:0]     out_id_ff;
   logic [fwsts_pkg::TIME_W-1:0]   out_time_ff;
   logic                           out_empty_ff;

   // Request fields.
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff       <= fwsts_pkg::op_type'(req_tuser);
         new_id_ff   <= req_tdata[fwsts_pkg::ID_W-1:0];
         new_time_ff <= req_tdata[fwsts_pkg::ID_W +: fwsts_pkg::TIME_W];
         query_ff    <= req_tdata[fwsts_pkg::ID_W + fwsts_pkg::TIME_W +: fwsts_pkg::QUERY_W];
      end
   end

   // Queue pointers and fill count.
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (cmd.do_enq) begin
         tail_in  = fwsts_pkg::next_slot(tail_ff);
         count_in = count_ff + 1'b1;
      end
      if (cmd.do_deq) begin
         head_in  = fwsts_pkg::next_slot(head_ff);
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // While walking, the word being examined is at walk_slot_ff and the next one is fetched.
   assign rd_addr = cmd.walk_step ? fwsts_pkg::next_slot(walk_slot_ff) : head_ff;

   always_ff @(posedge clock) begin
      if (cmd.do_enq) begin
         id_mem[tail_ff]   <= new_id_ff;
         time_mem[tail_ff] <= new_time_ff;
      end
      rd_id_ff   <= id_mem[rd_addr];
      rd_time_ff <= time_mem[rd_addr];
   end

   // Search walk.
   assign sum_next = sum_ff + fwsts_pkg::SUM_W'(rd_time_ff);

   always_comb begin
      walk_slot_in = walk_slot_ff;
      seen_in      = seen_ff;
      sum_in       = sum_ff;
      if (cmd.walk_start) begin
         walk_slot_in = head_ff;
         seen_in      = '0;
         sum_in       = '0;
      end else if (cmd.walk_step) begin
         walk_slot_in = fwsts_pkg::next_slot(walk_slot_ff);
         seen_in      = seen_ff + 1'b1;
         sum_in       = sum_next;
      end
   end

   always_ff @(posedge clock) begin
      walk_slot_ff <= walk_slot_in;
      seen_ff      <= seen_in;
      sum_ff       <= sum_in;
   end

   always_comb begin
      stat.op    = op_ff;
      stat.empty = (count_ff == '0);
      stat.full  = (count_ff == fwsts_pkg::CNT_W'(fwsts_pkg::DEPTH));
      stat.hit   = (sum_next > fwsts_pkg::SUM_W'(query_ff));
      stat.last  = ((seen_ff + 1'b1) == count_ff);
   end

   // Result staging and output word.
   always_ff @(posedge clock) begin
      if (cmd.res_we) begin
         res_status_ff <= cmd.res_status;
         res_id_ff     <= (cmd.res_kind == fwsts_pkg::RES_PEEK ||
                           cmd.res_kind == fwsts_pkg::RES_HIT) ? rd_id_ff : '0;
         res_time_ff   <= (cmd.res_kind == fwsts_pkg::RES_PEEK) ? rd_time_ff : '0;
      end
      if (cmd.out_load) begin
         out_status_ff <= res_status_ff;
         out_id_ff     <= res_id_ff;
         out_time_ff   <= res_time_ff;
         out_empty_ff  <= (count_ff == '0);
      end
   end

   assign rsp_tuser = out_status_ff;
   assign rsp_tdata = {{(fwsts_pkg::RSP_TDATA_W - fwsts_pkg::RSP_FIELDS_W){1'b0}},
                       out_empty_ff, out_time_ff, out_id_ff};

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= fwsts_pkg::CNT_W'(fwsts_pkg::DEPTH))
      else $error("fill count above depth");

   a_enq_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.do_enq |-> count_ff != fwsts_pkg::CNT_W'(fwsts_pkg::DEPTH))
      else $error("write into a full queue");

   a_deq_not_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.do_deq |-> count_ff != '0)
      else $error("removal from an empty queue");

   a_walk_bounded: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_step |-> seen_ff < count_ff)
      else $error("search walked past the stored entries");

endmodule

`default_nettype wire

>>> src/fwsts_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module fwsts_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   input  wire fwsts_pkg::dp_stat_type  stat,
   output fwsts_pkg::dp_cmd_type        cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_PEEK,
      S_WALK,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.res_kind   = fwsts_pkg::RES_CODE;
      cmd.res_status = fwsts_pkg::ST_OK;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            case (stat.op)
               fwsts_pkg::OP_ENQUEUE: begin
                  cmd.res_we = 1'b1;
                  if (stat.full) begin
                     cmd.res_status = fwsts_pkg::ST_FULL;
                  end else begin
                     cmd.do_enq = 1'b1;
                  end
                  state_in = S_DONE;
               end
               fwsts_pkg::OP_DEQUEUE: begin
                  cmd.res_we = 1'b1;
                  if (stat.empty) begin
                     cmd.res_status = fwsts_pkg::ST_EMPTY;
                  end else begin
                     cmd.do_deq = 1'b1;
                  end
                  state_in = S_DONE;
               end
               fwsts_pkg::OP_PEEK: begin
                  if (stat.empty) begin
                     cmd.res_we     = 1'b1;
                     cmd.res_status = fwsts_pkg::ST_EMPTY;
                     state_in       = S_DONE;
                  end else begin
                     // The head entry is fetched on this edge by the datapath read port.
                     state_in = S_PEEK;
                  end
               end
               fwsts_pkg::OP_FIND: begin
                  if (stat.empty) begin
                     cmd.res_we     = 1'b1;
                     cmd.res_status = fwsts_pkg::ST_NOT_FOUND;
                     state_in       = S_DONE;
                  end else begin
                     cmd.walk_start = 1'b1;
                     state_in       = S_WALK;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_PEEK: begin
            cmd.res_we   = 1'b1;
            cmd.res_kind = fwsts_pkg::RES_PEEK;
            state_in     = S_DONE;
         end
         S_WALK: begin
            cmd.walk_step = 1'b1;
            if (stat.hit) begin
               cmd.res_we   = 1'b1;
               cmd.res_kind = fwsts_pkg::RES_HIT;
               state_in     = S_DONE;
            end else if (stat.last) begin
               cmd.res_we     = 1'b1;
               cmd.res_status = fwsts_pkg::ST_NOT_FOUND;
               state_in       = S_DONE;
            end
         end
         S_DONE: begin
            // Wait until the output register is free or is being emptied this cycle.
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwrote an unread word");

   a_walk_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WALK |-> !stat.empty)
      else $error("search running on an empty queue");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> state_ff == S_IDLE && rsp_valid_ff)
      else $error("result load did not complete");

endmodule

`default_nettype wire

>>> src/fifo_with_service_time_search.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake              tdata (low bit up)                     tuser
// req      in   req_tvalid/req_tready  item_id, service_time, query_time, pad  opcode
// rsp      out  rsp_tvalid/rsp_tready  found_id, found_time, is_empty, pad    status
//
// Each word passes through idle, execute and done before the next is accepted; peek on a
// non-empty queue adds the peek state, and find on a non-empty queue adds a walk that visits
// n entries, where n is the number of entries visited (at most DEPTH).
// The single registered read port of the entry store sets the find rate: one entry per cycle.
// Reset is synchronous and empties the queue; the entry store itself is not cleared.
// A waiting result does not block acceptance; a stalled result holds the next one back.

module fifo_with_service_time_search (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // item_id [15:0], service_time [31:16], query_time [51:32], zero [55:52]
   input  wire logic [fwsts_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // opcode [1:0]
   input  wire logic [fwsts_pkg::OP_W-1:0]          req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // found_id [15:0], found_time [31:16], is_empty [32], zero [39:33]
   output logic [fwsts_pkg::RSP_TDATA_W-1:0]        rsp_tdata,
   // status [1:0]
   output logic [fwsts_pkg::STATUS_W-1:0]           rsp_tuser
);

   fwsts_pkg::dp_cmd_type  cmd;
   fwsts_pkg::dp_stat_type stat;

   fwsts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   fwsts_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

`default_nettype wire
